>>> src/oale_pkg.sv
package oale_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Result status codes carried in the output tuser.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned PosWidth    = 8;
  localparam int unsigned IndexWidth  = 7;
  localparam int unsigned LengthWidth = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the input transfer
    logic       init_ptr;  // set the walk pointer to its start for the operation
    logic       rd_en;     // read the store at the walk pointer
    logic       step;      // advance the walk pointer
    logic       shift_wr;  // write the last read entry one place up or down
    logic       put_wr;    // write the inserted value at its position
    logic       cnt_inc;
    logic       cnt_dec;
    logic       finish;    // load the result register
    logic [1:0] st;        // status to report with finish
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       pos_bad;
    logic       walk_empty;
    logic       list_empty;
    logic       ptr_last;
    logic       rd_vld;
    logic       hit;
    logic       out_busy;
  } sts_t;

endpackage

>>> src/ordered_array_list_engine_unit.sv
// Channel   Direction  Ports            Contents
// s_axis    in         tdata, tuser     one request: operation, value, position
// m_axis    out        tdata, tuser     one result: status, index, value, length
//
// A request goes from its transfer through a check and, as needed, walk, tail and put
// steps to its result; the next request can transfer in the cycle after it is loaded.
// The store has one read and one write port, so inserts, deletes and finds walk it
// one entry per cycle; reads do a single store read, and refused requests skip the walk.
// Reset clears the entry count and the handshake state; the store itself is not cleared.
// A finished result waits in the output register while the next request is taken in.
// A stalled output holds only the final step of the request behind it.
module ordered_array_list_engine_unit #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0 up: value [31:0], position [39:32].
  input  logic [39:0] s_axis_tdata_i,
  // Fields from bit 0 up: operation [1:0].
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0 up: found_index [6:0], read_value [38:7], length [46:39],
  // zero pad [47].
  output logic [47:0] m_axis_tdata_o,
  // Fields from bit 0 up: status [1:0].
  output logic [1:0]  m_axis_tuser_o
);
  import oale_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [IndexWidth-1:0]        out_index;
  logic signed [ValueWidth-1:0] out_value;
  logic [LengthWidth-1:0]       out_length;

  // The controller sequences each request through check, walk and write-back steps.
  oale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the store, the count, the walk pointer and the result register.
  oale_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser_i),
    .in_value_i   (s_axis_tdata_i[31:0]),
    .in_pos_i     (s_axis_tdata_i[39:32]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_index_o  (out_index),
    .out_value_o  (out_value),
    .out_length_o (out_length)
  );

  assign m_axis_tdata_o = {1'b0, out_length, out_value, out_index};

endmodule

>>> src/oale_ctrl.sv
module oale_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  oale_pkg::sts_t sts_i,
  output oale_pkg::cmd_t cmd_o
);
  import oale_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] st_q, st_d;
  logic       is_shift_op;

  assign in_ready_o  = (state_q == S_IDLE);
  assign is_shift_op = (sts_i.op == OP_INSERT) || (sts_i.op == OP_DELETE);

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    cmd_o.st = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.full) begin
              st_d    = ST_FULL;
              state_d = S_FIN;
            end else if (sts_i.pos_bad) begin
              st_d    = ST_POS;
              state_d = S_FIN;
            end else if (sts_i.walk_empty) begin
              state_d = S_PUT;
            end else begin
              cmd_o.init_ptr = 1'b1;
              state_d        = S_WALK;
            end
          end
          OP_DELETE: begin
            if (sts_i.pos_bad) begin
              st_d    = ST_POS;
              state_d = S_FIN;
            end else if (sts_i.walk_empty) begin
              cmd_o.cnt_dec = 1'b1;
              st_d          = ST_OK;
              state_d       = S_FIN;
            end else begin
              cmd_o.init_ptr = 1'b1;
              state_d        = S_WALK;
            end
          end
          OP_FIND: begin
            if (sts_i.list_empty) begin
              st_d    = ST_MISS;
              state_d = S_FIN;
            end else begin
              cmd_o.init_ptr = 1'b1;
              state_d        = S_WALK;
            end
          end
          default: begin
            if (sts_i.pos_bad) begin
              st_d    = ST_POS;
              state_d = S_FIN;
            end else begin
              cmd_o.init_ptr = 1'b1;
              state_d        = S_WALK;
            end
          end
        endcase
      end
      S_WALK: begin
        if ((sts_i.op == OP_FIND) && sts_i.hit) begin
          // Stop at the first match and keep its data and index.
          st_d    = ST_OK;
          state_d = S_FIN;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.shift_wr = sts_i.rd_vld && is_shift_op;
          if (sts_i.ptr_last) begin
            state_d = S_TAIL;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      S_TAIL: begin
        unique case (sts_i.op)
          OP_INSERT: begin
            cmd_o.shift_wr = 1'b1;
            state_d        = S_PUT;
          end
          OP_DELETE: begin
            cmd_o.shift_wr = 1'b1;
            cmd_o.cnt_dec  = 1'b1;
            st_d           = ST_OK;
            state_d        = S_FIN;
          end
          OP_FIND: begin
            st_d    = sts_i.hit ? ST_OK : ST_MISS;
            state_d = S_FIN;
          end
          default: begin
            st_d    = ST_OK;
            state_d = S_FIN;
          end
        endcase
      end
      S_PUT: begin
        cmd_o.put_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        st_d          = ST_OK;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

>>> src/oale_dp.sv
module oale_dp #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  oale_pkg::cmd_t                        cmd_i,
  output oale_pkg::sts_t                        sts_o,
  input  logic [1:0]                            in_op_i,
  input  logic signed [oale_pkg::ValueWidth-1:0] in_value_i,
  input  logic [oale_pkg::PosWidth-1:0]         in_pos_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            out_status_o,
  output logic [oale_pkg::IndexWidth-1:0]       out_index_o,
  output logic signed [oale_pkg::ValueWidth-1:0] out_value_o,
  output logic [oale_pkg::LengthWidth-1:0]      out_length_o
);
  import oale_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned EW = ((CW > PosWidth) ? CW : PosWidth) + 1;

  logic [1:0]                   op_q;
  logic signed [ValueWidth-1:0] val_q;
  logic [PosWidth-1:0]          pos_q;
  logic [CW-1:0]                cnt_q;
  logic [AW-1:0]                ptr_q, ptr_d;
  logic [AW-1:0]                rd_idx_q;
  logic                         rd_vld_q;
  logic signed [ValueWidth-1:0] rd_data_q;
  logic signed [ValueWidth-1:0] mem_q [CAPACITY];

  logic                         out_valid_q;
  logic [1:0]                   res_st_q;
  logic [IndexWidth-1:0]        res_idx_q;
  logic signed [ValueWidth-1:0] res_val_q;
  logic [LengthWidth-1:0]       res_len_q;

  logic [EW-1:0]                posx, cntx, ptrx;
  logic                         we;
  logic [AW-1:0]                wa;
  logic signed [ValueWidth-1:0] wd;

  assign posx = EW'(pos_q);
  assign cntx = EW'(cnt_q);
  assign ptrx = EW'(ptr_q);

  always_comb begin
    sts_o          = '0;
    sts_o.op       = op_q;
    sts_o.full     = (cntx >= EW'(CAPACITY));
    sts_o.list_empty = (cnt_q == '0);
    sts_o.rd_vld   = rd_vld_q;
    sts_o.hit      = rd_vld_q && (rd_data_q == val_q);
    sts_o.out_busy = out_valid_q && !out_ready_i;
    case (op_q)
      OP_INSERT: begin
        sts_o.pos_bad    = (posx == '0) || (posx > cntx + EW'(1));
        sts_o.walk_empty = (posx == cntx + EW'(1));
        sts_o.ptr_last   = (ptrx + EW'(1) == posx);
      end
      OP_DELETE: begin
        sts_o.pos_bad    = (posx == '0) || (posx > cntx);
        sts_o.walk_empty = (posx == cntx);
        sts_o.ptr_last   = (ptrx + EW'(1) == cntx);
      end
      OP_FIND: begin
        sts_o.ptr_last = (ptrx + EW'(1) == cntx);
      end
      default: begin
        sts_o.pos_bad  = (posx >= cntx);
        sts_o.ptr_last = 1'b1;
      end
    endcase
  end

  // Walk pointer: inserts walk down from the last entry, the rest walk up.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.init_ptr) begin
      case (op_q)
        OP_INSERT: ptr_d = AW'(cntx - EW'(1));
        OP_FIND:   ptr_d = '0;
        default:   ptr_d = AW'(posx);
      endcase
    end else if (cmd_i.step) begin
      ptr_d = (op_q == OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
    end
  end

  // Store write port: shifted entry during a walk, or the inserted value.
  always_comb begin
    we = cmd_i.shift_wr || cmd_i.put_wr;
    if (cmd_i.put_wr) begin
      wa = AW'(posx - EW'(1));
      wd = val_q;
    end else begin
      wa = (op_q == OP_INSERT) ? rd_idx_q + AW'(1) : rd_idx_q - AW'(1);
      wd = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[ptr_q];
      rd_idx_q  <= ptr_q;
    end
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      val_q <= in_value_i;
      pos_q <= in_pos_i;
    end
    ptr_q <= ptr_d;
    if (cmd_i.finish) begin
      res_st_q  <= cmd_i.st;
      res_idx_q <= ((op_q == OP_FIND) && (cmd_i.st == ST_OK)) ? IndexWidth'(rd_idx_q) : '0;
      res_val_q <= ((op_q == OP_READ) && (cmd_i.st == ST_OK)) ? rd_data_q : '0;
      res_len_q <= LengthWidth'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = res_st_q;
  assign out_index_o  = res_idx_q;
  assign out_value_o  = res_val_q;
  assign out_length_o = res_len_q;

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import oale_pkg::*;

  localparam int Capacity   = 128;
  localparam int ClkPeriod  = 20;
  localparam int ResetCycles = 10;
  // The slowest correct run stays far below this limit, so it leaves a wide margin.
  localparam int CycleLimit = 1_000_000;
  localparam int HoldCycles = 400;
  localparam int MaxReports = 10;

  // One result as the block reports it.
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  found_index;
    logic [31:0] read_value;
    logic [7:0]  length;
  } list_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // Fields from bit 0 up: value [31:0], position [39:32].
  logic [39:0] s_axis_tdata_i;
  // Fields from bit 0 up: operation [1:0].
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // Fields from bit 0 up: found_index [6:0], read_value [38:7], length [46:39], pad [47].
  logic [47:0] m_axis_tdata_o;
  // Fields from bit 0 up: status [1:0].
  logic [1:0]  m_axis_tuser_o;

  // Predicted list contents, in list order, and the results still to arrive.
  logic [31:0]  list_contents[$];
  list_result_t expected_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_active    = 1'b0;
  int error_count    = 0;
  int cycle_count;

  ordered_array_list_engine_unit #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_READ;
    m_axis_tready_i = 1'b0;
  end

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Applies one accepted request to the predicted list and returns its result.
  function automatic list_result_t predict_result(logic [1:0] op, logic [31:0] value,
                                                  logic [7:0] pos);
    list_result_t res;
    int size;
    size = list_contents.size();
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        // A full list is refused before the position is looked at.
        if (size >= Capacity) begin
          res.status = ST_FULL;
        end else if (pos < 1 || int'(pos) > size + 1) begin
          res.status = ST_POS;
        end else begin
          list_contents.insert(int'(pos) - 1, value);
        end
      end
      OP_DELETE: begin
        if (pos < 1 || int'(pos) > size) begin
          res.status = ST_POS;
        end else begin
          list_contents.delete(int'(pos) - 1);
        end
      end
      OP_FIND: begin
        res.status = ST_MISS;
        for (int j = 0; j < size; j++) begin
          if (list_contents[j] == value) begin
            res.status = ST_OK;
            res.found_index = 7'(j);
            break;
          end
        end
      end
      default: begin
        if (int'(pos) >= size) begin
          res.status = ST_POS;
        end else begin
          res.read_value = list_contents[pos];
        end
      end
    endcase
    res.length = 8'(list_contents.size());
    return res;
  endfunction

  // Offers one request, holding it until the block takes it; valid is only
  // lowered when the sender decides to idle before the next request.
  task automatic send_request(logic [1:0] op, logic [31:0] value, logic [7:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pos, value};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_results.push_back(predict_result(op, value, pos));
  endtask

  // A value from a non-empty list for from_list_pct percent of calls, else an extreme or a random word.
  function automatic logic [31:0] pick_value(int from_list_pct);
    if (list_contents.size() > 0 && $urandom_range(99) < from_list_pct) begin
      return list_contents[$urandom_range(list_contents.size() - 1)];
    end
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Most positions are in range for the current list; some are anything at all.
  task automatic send_random_request(int insert_pct);
    logic [1:0]  op;
    logic [7:0]  pos;
    logic [31:0] value;
    int          size;
    size = list_contents.size();
    if ($urandom_range(99) < insert_pct) begin
      op = OP_INSERT;
    end else begin
      case ($urandom_range(2))
        0: op = OP_DELETE;
        1: op = OP_FIND;
        default: op = OP_READ;
      endcase
    end
    value = pick_value(op == OP_FIND ? 70 : 25);
    if ($urandom_range(99) < 12 || op == OP_FIND) begin
      pos = 8'($urandom_range(255));
    end else begin
      case (op)
        OP_INSERT: pos = (size < Capacity) ? 8'($urandom_range(size + 1, 1))
                                           : 8'($urandom_range(255));
        OP_DELETE: pos = (size > 0) ? 8'($urandom_range(size, 1)) : 8'd1;
        default:   pos = (size > 0) ? 8'($urandom_range(size - 1, 0)) : 8'd0;
      endcase
    end
    send_request(op, value, pos);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Empty-list refusals, the value extremes, duplicates, and deletes at the
  // head, the tail and the middle.
  task automatic test_directed();
    set_idling(0, 0);
    send_request(OP_FIND,   32'd0,         8'd0);
    send_request(OP_READ,   32'd0,         8'd0);
    send_request(OP_DELETE, 32'd0,         8'd0);
    send_request(OP_DELETE, 32'd0,         8'd1);
    send_request(OP_INSERT, 32'd7,         8'd0);
    send_request(OP_INSERT, 32'd7,         8'd2);
    send_request(OP_INSERT, 32'h8000_0000, 8'd1);
    send_request(OP_INSERT, 32'h7fff_ffff, 8'd2);
    send_request(OP_INSERT, 32'hffff_ffff, 8'd1);
    send_request(OP_INSERT, 32'h0000_0000, 8'd4);
    send_request(OP_INSERT, 32'hffff_ffff, 8'd3);
    send_request(OP_FIND,   32'hffff_ffff, 8'd255);
    send_request(OP_FIND,   32'h0000_0000, 8'd0);
    send_request(OP_FIND,   32'h7fff_ffff, 8'd0);
    send_request(OP_FIND,   32'd12345,     8'd0);
    send_request(OP_READ,   32'd0,         8'd0);
    send_request(OP_READ,   32'd0,         8'd4);
    send_request(OP_READ,   32'd0,         8'd5);
    send_request(OP_READ,   32'd0,         8'd255);
    send_request(OP_DELETE, 32'd0,         8'd6);
    send_request(OP_DELETE, 32'd0,         8'd255);
    send_request(OP_DELETE, 32'd0,         8'd5);
    send_request(OP_DELETE, 32'd0,         8'd1);
    send_request(OP_DELETE, 32'd0,         8'd2);
  endtask

  // Fills the list to capacity, then probes the full list at its edges.
  task automatic test_fill_to_capacity();
    set_idling(0, 0);
    while (list_contents.size() < Capacity) begin
      send_request(OP_INSERT, 32'h5a5a_0000 ^ 32'(list_contents.size()), 8'd1);
    end
    send_request(OP_INSERT, 32'd1,         8'd0);
    send_request(OP_INSERT, 32'd1,         8'd255);
    send_request(OP_FIND,   list_contents[Capacity - 1], 8'd0);
    send_request(OP_READ,   32'd0,         8'(Capacity - 1));
    send_request(OP_READ,   32'd0,         8'(Capacity));
    send_request(OP_DELETE, 32'd0,         8'(Capacity + 1));
    send_request(OP_DELETE, 32'd0,         8'(Capacity));
    send_request(OP_INSERT, 32'h8000_0000, 8'(Capacity));
    send_request(OP_DELETE, 32'd0,         8'd1);
  endtask

  task automatic test_random_traffic(int items, int insert_pct, int send_pct, int recv_pct);
    set_idling(send_pct, recv_pct);
    repeat (items) send_random_request(insert_pct);
  endtask

  task automatic hold_receiver(int cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_active <= 1'b0;
  endtask

  // The receiver refuses results for a long stretch while requests keep
  // coming, so the output register and the request behind it both fill and
  // the input has to stall.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    fork
      hold_receiver(HoldCycles);
      repeat (10) send_random_request(20);
    join
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  // Compares every result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status      = m_axis_tuser_o;
      got.found_index = m_axis_tdata_o[6:0];
      got.read_value  = m_axis_tdata_o[38:7];
      got.length      = m_axis_tdata_o[46:39];
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("unexpected result: status %0d index %0d value %h length %0d",
                   got.status, got.found_index, got.read_value, got.length);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.found_index !== want.found_index ||
            got.read_value !== want.read_value || got.length !== want.length) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("mismatch: expected status %0d index %0d value %h length %0d, %s",
                     want.status, want.found_index, want.read_value, want.length,
                     $sformatf("got status %0d index %0d value %h length %0d",
                               got.status, got.found_index, got.read_value, got.length));
          end
        end
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk_i);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_to_capacity();
    test_random_traffic(150, 35, 0, 0);
    test_random_traffic(150, 30, 86, 0);
    test_random_traffic(150, 25, 0, 86);
    test_output_backpressure();
    test_random_traffic(150, 45, 22, 22);
    test_random_traffic(150, 60, 0, 0);

    // Drain: wait for every prediction, then watch for stray results.
    s_axis_tvalid_i <= 1'b0;
    set_idling(0, 0);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (Capacity + 10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
